>>> design/assert_macros.svh
// Assertion macros shared by the sieve scan unit.
// Included by every design file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted
`define LSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication built on the clocked form
`define LSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  `LSA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> design/lsa_pkg.sv
// Shared types and constants for the log sieve accumulate and scan unit.
// No dependencies; used by lsa_store, lsa_core and the top level.
package lsa_pkg;

  // Index width: a root plus one stride step always fits
  localparam int IDX_W = 21;

  // Entries with any of these bits set are large enough to report
  localparam logic [7:0] HIGH_BITS_MASK = 8'hC0;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_SIEVE,
    CMD_SCAN,
    CMD_NOP
  } lsa_cmd_t;

  typedef enum logic [1:0] {
    CFG_FILL,
    CFG_THRESHOLD,
    CFG_LENGTH
  } lsa_cfg_idx_t;

  typedef struct packed {
    lsa_cmd_t    cmd;
    logic [19:0] prime;
    logic [7:0]  log_size;
    logic [19:0] root_first;
    logic [19:0] root_second;
    logic [12:0] group_index;
  } lsa_item_t;

  typedef struct packed {
    logic [7:0] hit_mask;
    logic       any_hit;
  } lsa_result_t;

  // Single-port request into the sieve memory
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wdata;
  } lsa_mem_req_t;

endpackage

>>> design/log_sieve_accumulate_scan_unit.sv
// Log sieve accumulate and scan unit: streaming input of commands, one result
// word per command; uses lsa_pkg, lsa_core, lsa_store and assert_macros.svh.
//
// Usage:
//   in_*  : one command word per handshake; in_tuser holds the command.
//   out_* : one result word per command; hit_mask and any_hit are zero
//           except for a scan.
//   cfg_* : write fill value, threshold and sieve length while idle.
// Work done per command before the result reaches the output stage:
//   clear: one memory write a cycle for each entry in use.
//   sieve: for each hit a read, then a write back through the single memory
//          port, over the hits of both roots.
//   scan : one lane read a cycle, GROUP_LANES lanes.
//   no-op, or a sieve with a zero prime or zero second root: no memory access.
// One command is in work at a time; in_tready is high only while the
// sequencer is idle, so a new command is taken at the earliest in the
// cycle after the previous result reaches the output register. That register
// frees the sequencer while the receiver stalls; a second result waits in
// the sequencer until out_tready drains it. Reset clears control state and
// registers (length 65536); the sieve memory holds garbage until a clear.
`include "assert_macros.svh"

module log_sieve_accumulate_scan_unit #(
  parameter int SIEVE_ENTRIES = 65536,
  parameter int GROUP_LANES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tuser: cmd[1:0]
  // in_tdata: prime[19:0], log_size[27:20], root_first[47:28],
  //           root_second[67:48], group_index[80:68], zero fill [87:81]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [87:0] in_tdata,
  // out_tdata: hit_mask[7:0], any_hit[8], zero fill [15:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  lsa_pkg::lsa_item_t         item;
  lsa_pkg::lsa_result_t       res;
  lsa_pkg::lsa_mem_req_t      req;
  logic [7:0]                 rdata;
  logic                       core_idle;
  logic                       res_valid;
  logic                       res_ready;
  logic [lsa_pkg::IDX_W-1:0]  limit;

  logic [7:0]                 fill_r;
  logic [7:0]                 thr_r;
  logic [16:0]                len_r;
  logic                       out_valid_r;
  lsa_pkg::lsa_result_t       out_data_r;

  // Unpack the command word
  assign item.cmd         = lsa_pkg::lsa_cmd_t'(in_tuser);
  assign item.prime       = in_tdata[19:0];
  assign item.log_size    = in_tdata[27:20];
  assign item.root_first  = in_tdata[47:28];
  assign item.root_second = in_tdata[67:48];
  assign item.group_index = in_tdata[80:68];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 8'd0;
      thr_r  <= 8'd0;
      len_r  <= 17'h10000;
    end else if (cfg_we) begin
      case (lsa_pkg::lsa_cfg_idx_t'(cfg_index))
        lsa_pkg::CFG_FILL:      fill_r <= cfg_wdata[7:0];
        lsa_pkg::CFG_THRESHOLD: thr_r  <= cfg_wdata[7:0];
        lsa_pkg::CFG_LENGTH:    len_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp the length to the memory depth
  assign limit = (lsa_pkg::IDX_W'(len_r) > lsa_pkg::IDX_W'(SIEVE_ENTRIES)) ?
                 lsa_pkg::IDX_W'(SIEVE_ENTRIES) : lsa_pkg::IDX_W'(len_r);

  assign in_tready = core_idle;

  lsa_core #(
    .GROUP_LANES(GROUP_LANES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid && in_tready),
    .item      (item),
    .idle      (core_idle),
    .fill_value(fill_r),
    .threshold (thr_r),
    .limit     (limit),
    .req       (req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  lsa_store #(
    .ENTRIES(SIEVE_ENTRIES)
  ) u_store (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.any_hit, out_data_r.hit_mask};

  `LSA_ASSERT_IMPL(a_any_hit, out_valid_r,
    out_data_r.any_hit == (out_data_r.hit_mask != 8'd0),
    "any_hit disagrees with hit_mask")

endmodule

>>> design/lsa_store.sv
// Byte-wide sieve memory: one access per cycle, registered read data.
// Depends on lsa_pkg for the request struct.
module lsa_store #(
  parameter int ENTRIES = 65536
) (
  input  logic                clk,
  input  lsa_pkg::lsa_mem_req_t req,
  output logic [7:0]          rdata
);

  localparam int AW = $clog2(ENTRIES);

  logic [7:0] mem [ENTRIES];
  logic [7:0] rdata_r;

  // Write and read at the requested entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr[AW-1:0]];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/lsa_core.sv
// Sequencer around one shared index adder and limit compare.
// Drives clear, stride accumulate and group scan through lsa_store.
// Depends on lsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lsa_core #(
  parameter int GROUP_LANES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  lsa_pkg::lsa_item_t         item,
  output logic                       idle,
  input  logic [7:0]                 fill_value,
  input  logic [7:0]                 threshold,
  input  logic [lsa_pkg::IDX_W-1:0]  limit,
  output lsa_pkg::lsa_mem_req_t      req,
  input  logic [7:0]                 rdata,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lsa_pkg::lsa_result_t       res
);

  localparam int LCW = $clog2(GROUP_LANES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLR,
    ST_SV_RD,
    ST_SV_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  lsa_pkg::lsa_item_t         item_r, item_nxt;
  logic [lsa_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       pass_r, pass_nxt;
  logic [LCW-1:0]             lane_r, lane_nxt;
  logic                       inr_r, inr_nxt;
  logic [7:0]                 mask_r, mask_nxt;

  logic [lsa_pkg::IDX_W-1:0]  addend;
  logic [lsa_pkg::IDX_W-1:0]  sum;
  logic                       below;
  logic                       lane_hit;
  logic [2:0]                 prev_lane;

  // Shared unit: one index add and one compare against the limit
  assign addend = (state_r == ST_SV_WR) ? lsa_pkg::IDX_W'(item_r.prime)
                                        : lsa_pkg::IDX_W'(1);
  assign sum    = idx_r + addend;
  assign below  = (idx_r < limit);

  // Candidate test on the word read for the previous lane
  assign lane_hit  = inr_r && ((rdata & lsa_pkg::HIGH_BITS_MASK) != 8'd0) &&
                     (rdata > threshold);
  assign prev_lane = 3'(lane_r - LCW'(1));

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    item_nxt  = item_r;
    idx_nxt   = idx_r;
    pass_nxt  = pass_r;
    lane_nxt  = lane_r;
    inr_nxt   = inr_r;
    mask_nxt  = mask_r;
    req.we    = 1'b0;
    req.re    = 1'b0;
    req.addr  = idx_r;
    req.wdata = fill_value;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          item_nxt = item;
          mask_nxt = 8'd0;
          pass_nxt = 1'b0;
          lane_nxt = '0;
          inr_nxt  = 1'b0;
          case (item.cmd)
            lsa_pkg::CMD_CLEAR: begin
              idx_nxt   = '0;
              state_nxt = ST_CLR;
            end
            lsa_pkg::CMD_SIEVE: begin
              idx_nxt = lsa_pkg::IDX_W'(item.root_first);
              if (item.root_second == 20'd0 || item.prime == 20'd0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SV_RD;
              end
            end
            lsa_pkg::CMD_SCAN: begin
              idx_nxt   = lsa_pkg::IDX_W'(item.group_index) *
                          lsa_pkg::IDX_W'(GROUP_LANES);
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      // Fill one entry a cycle until the limit
      ST_CLR: begin
        if (below) begin
          req.we  = 1'b1;
          idx_nxt = sum;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      // Fetch the next hit, or switch to the second root
      ST_SV_RD: begin
        if (below) begin
          req.re    = 1'b1;
          state_nxt = ST_SV_WR;
        end else if (!pass_r) begin
          pass_nxt = 1'b1;
          idx_nxt  = lsa_pkg::IDX_W'(item_r.root_second);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      // Write back the accumulated byte and advance by the prime
      ST_SV_WR: begin
        req.we    = 1'b1;
        req.wdata = rdata + item_r.log_size;
        idx_nxt   = sum;
        state_nxt = ST_SV_RD;
      end
      // Read one lane a cycle, judge the lane read the cycle before
      ST_SCAN: begin
        if (lane_r < LCW'(GROUP_LANES)) begin
          req.re  = below;
          inr_nxt = below;
          idx_nxt = sum;
        end
        if (lane_r != '0) begin
          mask_nxt[prev_lane] = lane_hit;
        end
        if (lane_r == LCW'(GROUP_LANES)) begin
          state_nxt = ST_DONE;
        end else begin
          lane_nxt = lane_r + LCW'(1);
        end
      end
      // Hold the result until the output register takes it
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    item_r <= item_nxt;
    idx_r  <= idx_nxt;
    pass_r <= pass_nxt;
    lane_r <= lane_nxt;
    inr_r  <= inr_nxt;
    mask_r <= mask_nxt;
  end

  assign idle         = (state_r == ST_IDLE);
  assign res_valid    = (state_r == ST_DONE);
  assign res.hit_mask = mask_r;
  assign res.any_hit  = (mask_r != 8'd0);

  `LSA_ASSERT_IMPL(a_write_in_use, req.we, req.addr < limit,
    "sieve write outside the entries in use")
  `LSA_ASSERT_IMPL(a_wr_after_rd, state_r == ST_SV_WR, $past(state_r) == ST_SV_RD,
    "accumulate write without a preceding read")
  `LSA_ASSERT_IMPL(a_mask_lanes, state_r == ST_DONE, (mask_r >> GROUP_LANES) == 8'd0,
    "hit mask bit set beyond the group lanes")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for log_sieve_accumulate_scan_unit.
// Drives clear, sieve, scan and no-op words through the input stream and checks
// every result word against an in-bench sieve image; needs lsa_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int ENTRIES = 65536;
  localparam int LANES   = 8;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser   = '0;
  logic [87:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = '0;
  logic [16:0] cfg_wdata  = '0;

  // Sieve image and register copies used for prediction
  logic [7:0]  sieve_image [0:ENTRIES-1];
  logic [7:0]  fill_reg   = 8'h00;
  logic [7:0]  thr_reg    = 8'h00;
  logic [16:0] length_reg = 17'h10000;

  lsa_pkg::lsa_item_t   pending_words [$];
  lsa_pkg::lsa_result_t expected_masks [$];
  int unsigned words_queued  = 0;
  int unsigned results_seen  = 0;
  int unsigned error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        word_taken    = 1'b0;

  log_sieve_accumulate_scan_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Lay the data fields out as the input stream expects, prime in the lowest bits
  function automatic logic [87:0] pack_word(input lsa_pkg::lsa_item_t it);
    logic [87:0] w;
    w = '0;
    w[19:0]  = it.prime;
    w[27:20] = it.log_size;
    w[47:28] = it.root_first;
    w[67:48] = it.root_second;
    w[80:68] = it.group_index;
    return w;
  endfunction

  // Apply one accepted word to the sieve image and work out its hit mask
  task automatic predict_hit_mask(input logic [1:0] u, input logic [87:0] w,
                                  output logic [7:0] mask);
    lsa_pkg::lsa_cmd_t cmd;
    int unsigned stride, root_a, root_b, limit, base, idx;
    logic [7:0]  amount, v;
    cmd    = lsa_pkg::lsa_cmd_t'(u);
    stride = 32'(w[19:0]);
    amount = w[27:20];
    root_a = 32'(w[47:28]);
    root_b = 32'(w[67:48]);
    base   = 32'(w[80:68]) * LANES;
    limit  = (32'(length_reg) > ENTRIES) ? ENTRIES : 32'(length_reg);
    mask   = '0;
    case (cmd)
      lsa_pkg::CMD_CLEAR: begin
        for (idx = 0; idx < limit; idx++) sieve_image[16'(idx)] = fill_reg;
      end
      lsa_pkg::CMD_SIEVE: begin
        // a zero stride or zero second root leaves the image alone
        if (stride != 0 && root_b != 0) begin
          for (idx = root_a; idx < limit; idx += stride)
            sieve_image[16'(idx)] = sieve_image[16'(idx)] + amount;
          for (idx = root_b; idx < limit; idx += stride)
            sieve_image[16'(idx)] = sieve_image[16'(idx)] + amount;
        end
      end
      lsa_pkg::CMD_SCAN: begin
        for (int k = 0; k < LANES; k++) begin
          idx = base + 32'(k);
          if (idx < limit) begin
            v = sieve_image[16'(idx)];
            if ((v & lsa_pkg::HIGH_BITS_MASK) != 0 && v > thr_reg) mask[3'(k)] = 1'b1;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Present the next pending word once the previous one has gone
  always @(negedge clk) begin
    lsa_pkg::lsa_item_t next_word;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_tuser  <= next_word.cmd;
        in_tdata  <= pack_word(next_word);
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result stream at random
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check result words, then predict for the input word taken at this edge
  always @(posedge clk) begin
    lsa_pkg::lsa_result_t want;
    logic [7:0]  mask;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_masks.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, out_tdata);
          error_count++;
        end else begin
          want = expected_masks.pop_front();
          results_seen++;
          if (out_tdata[7:0] !== want.hit_mask) begin
            $display("%0t: hit_mask expected %h, actual %h", $time, want.hit_mask,
                     out_tdata[7:0]);
            error_count++;
          end
          if (out_tdata[8] !== want.any_hit) begin
            $display("%0t: any_hit expected %b, actual %b", $time, want.any_hit,
                     out_tdata[8]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_hit_mask(in_tuser, in_tdata, mask);
        want.hit_mask = mask;
        want.any_hit  = (mask != 8'd0);
        expected_masks.push_back(want);
      end
    end
    word_taken <= rst_n && in_tvalid && in_tready;
  end

  task automatic send(input lsa_pkg::lsa_cmd_t cmd, input logic [19:0] prime,
                      input logic [7:0] ls, input logic [19:0] r1,
                      input logic [19:0] r2, input logic [12:0] grp);
    lsa_pkg::lsa_item_t it;
    it.cmd         = cmd;
    it.prime       = prime;
    it.log_size    = ls;
    it.root_first  = r1;
    it.root_second = r2;
    it.group_index = grp;
    pending_words.push_back(it);
    words_queued++;
  endtask

  // Mostly well-formed clear, sieve and scan words, with some stray ones
  task automatic send_random(input int unsigned limit);
    lsa_pkg::lsa_item_t it;
    int unsigned pick;
    it.cmd         = lsa_pkg::CMD_NOP;
    it.prime       = 20'($urandom);
    it.log_size    = 8'($urandom);
    it.root_first  = 20'($urandom);
    it.root_second = 20'($urandom);
    it.group_index = 13'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.cmd = lsa_pkg::CMD_CLEAR;
    end else if (pick < 55) begin
      it.cmd = lsa_pkg::CMD_SIEVE;
      pick = $urandom_range(9);
      if (pick < 6) it.prime = 20'($urandom_range(40, 1));
      else if (pick < 9) it.prime = 20'($urandom_range(2048, 41));
      if (it.prime != 0) begin
        it.root_first  = 20'($urandom % it.prime);
        it.root_second = ($urandom_range(9) == 0) ? it.root_first
                                                  : 20'($urandom % it.prime);
        if (it.root_second == 0) it.root_second = it.prime - 20'd1;
      end
    end else if (pick < 90) begin
      it.cmd = lsa_pkg::CMD_SCAN;
      it.group_index = 13'($urandom_range((limit + 7) / 8, 0));
    end else if (pick < 95) begin
      it.cmd = lsa_pkg::CMD_SIEVE;
    end else if (pick < 98) begin
      it.cmd = lsa_pkg::CMD_NOP;
    end else begin
      it.cmd = lsa_pkg::CMD_SCAN;
    end
    pending_words.push_back(it);
    words_queued++;
  endtask

  // Write all three registers back to back; junk in the unused data bits
  task automatic set_config(input logic [7:0] fill, input logic [7:0] thr,
                            input logic [16:0] len);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= lsa_pkg::CFG_FILL;
    cfg_wdata <= {9'($urandom), fill};
    @(negedge clk);
    cfg_index <= lsa_pkg::CFG_THRESHOLD;
    cfg_wdata <= {9'($urandom), thr};
    @(negedge clk);
    cfg_index <= lsa_pkg::CFG_LENGTH;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    fill_reg   = fill;
    thr_reg    = thr;
    length_reg = len;
  endtask

  // Hold until every queued word has produced its result
  task automatic drain();
    while (results_seen < words_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned phase_len [12];
    logic [7:0]  fill, thr;
    phase_len = '{64, 1, 200, 512, 13, 600, 96, 255, 8, 440, 128, 333};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Registers at reset values: full-length clear, hits at both ends, equal roots
    send(lsa_pkg::CMD_CLEAR, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'hFFFFF, 8'd200, 20'd0, 20'd65535, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd16384, 8'h55, 20'd3, 20'd3, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'h1FFF);
    send(lsa_pkg::CMD_SCAN, 20'hFFFFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 13'd2048);
    send(lsa_pkg::CMD_NOP, 20'hFFFFF, 8'hFF, 20'hFFFFF, 20'hFFFFF, 13'h1FFF);
    drain();

    // Length beyond the array acts as the whole array; zero stride and zero root skip
    set_config(8'hFF, 8'hFE, 17'h1FFFF);
    send(lsa_pkg::CMD_CLEAR, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd0, 8'd1, 20'd0, 20'd1, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd3, 8'd1, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'hFFFFF, 8'd1, 20'd65535, 20'd65535, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'h1FFF);
    drain();

    // Zero length: nothing in use
    set_config(8'h80, 8'h00, 17'd0);
    send(lsa_pkg::CMD_CLEAR, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd2, 8'h40, 20'd0, 20'd1, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    drain();

    // Single entry in use, wrap to zero on add
    set_config(8'h40, 8'h3F, 17'd1);
    send(lsa_pkg::CMD_CLEAR, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd1, 8'hC0, 20'd0, 20'd5, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    drain();

    // Roots above the stride, a group straddling the end and one past it
    set_config(8'h3F, 8'h00, 17'd100);
    send(lsa_pkg::CMD_CLEAR, 20'd0, 8'd0, 20'd0, 20'd0, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd7, 8'd1, 20'd10, 20'd3, 13'd0);
    send(lsa_pkg::CMD_SIEVE, 20'd5, 8'd1, 20'd1, 20'd2, 13'd0);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd1);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd12);
    send(lsa_pkg::CMD_SCAN, 20'd0, 8'd0, 20'd0, 20'd0, 13'd13);
    drain();

    // Random phases over the four idling modes; the whole array is cleared above
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      fill = 8'($urandom);
      thr  = 8'($urandom_range(160));
      if (ph == 0) begin fill = 8'h00; thr = 8'h00; end
      if (ph == 1) begin fill = 8'hFF; thr = 8'hFF; end
      if (ph == 2) begin fill = 8'h40; thr = 8'hBF; end
      set_config(fill, thr, 17'(phase_len[ph]));
      for (int n = 0; n < 63; n++) send_random(phase_len[ph]);
      drain();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_masks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/lsa_pkg.sv
design/lsa_store.sv
design/lsa_core.sv
design/log_sieve_accumulate_scan_unit.sv
tb/testbench.sv
